[hw/rtl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QW          = 16;   // quaternion component width
    localparam int AW          = 25;   // output angle width
    localparam int SUMW        = 36;   // product term sums, 28 fraction bits
    localparam int XW          = 40;   // CORDIC x/y datapath
    localparam int ZW          = 34;   // CORDIC angle, 30 fraction bits
    localparam int SQW         = 58;   // square root remainder / root
    localparam int SQ_STEPS    = 29;   // root bits for a 57-bit radicand
    localparam int DLY         = SQ_STEPS + 2;
    localparam int STEPS_DEF   = 16;
    localparam int TAB_LEN     = 31;
    localparam int DEGK_W      = 30;

    localparam logic signed [ZW-1:0]   HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic [DEGK_W-1:0]      DEG_K_Q24   = DEGK_W'(961263669);
    localparam logic signed [SUMW-1:0] ONE_Q28     = SUMW'(64'sd268435456);

    // atan(2^-i), 30 fraction bits
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

[hw/rtl/quaternion_to_euler.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Fully pipelined unit quaternion to ZYX Euler angle converter.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_quat_w/x/y/z (signed Q1.14) and pulse start; a beat is taken at
//   every edge with start high and busy low. busy is high only while reset
//   is held and for the first cycle after, so one beat per cycle is taken.
//   Each beat returns one result beat (o_roll_angle, o_pitch_angle,
//   o_yaw_angle, o_pitch_clamped) marked by o_valid for exactly one cycle,
//   in the order the beats were taken. The receiver
//   cannot stall, so nothing in the pipe ever waits.
//   Latency is set by the pitch path: products, sums, square, radicand,
//   a 29 stage restoring square root, the fold stage plus CORDIC_STEPS
//   CORDIC stages, and two output stages for the unit conversion
//   (the degree scale multiply is split in two 17 bit halves).
//   Roll and yaw arguments travel in a delay line beside the square root.
//   i_cfg_we writes i_cfg_data into the degrees select (0 radians,
//   1 degrees); write it only while no beat is in flight.
//   Reset clears the valid pipe and selects radians.
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = qte_pkg::STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data,
    input  logic signed [qte_pkg::QW-1:0]   i_quat_w,
    input  logic signed [qte_pkg::QW-1:0]   i_quat_x,
    input  logic signed [qte_pkg::QW-1:0]   i_quat_y,
    input  logic signed [qte_pkg::QW-1:0]   i_quat_z,
    output logic                            o_valid,
    output logic signed [qte_pkg::AW-1:0]   o_roll_angle,
    output logic signed [qte_pkg::AW-1:0]   o_pitch_angle,
    output logic signed [qte_pkg::AW-1:0]   o_yaw_angle,
    output logic                            o_pitch_clamped
);
    import qte_pkg::*;

    localparam int LAT = CORDIC_STEPS + DLY + 5;
    localparam int PW  = 2 * QW;

    // ---------------- control: valid pipe, config, busy ----------------
    logic           r_busy;
    logic           r_deg;
    logic [LAT-1:0] r_vld;
    logic           take;

    assign take = start && !busy;
    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_deg  <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_deg <= i_cfg_data;
            end
            r_vld <= {r_vld[LAT-2:0], take};
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [PW-1:0] r_wx, r_yz, r_wz, r_xy, r_wy, r_zx, r_xx, r_yy, r_zz;

    always_ff @(posedge i_clk) begin
        r_wx <= i_quat_w * i_quat_x;
        r_yz <= i_quat_y * i_quat_z;
        r_wz <= i_quat_w * i_quat_z;
        r_xy <= i_quat_x * i_quat_y;
        r_wy <= i_quat_w * i_quat_y;
        r_zx <= i_quat_z * i_quat_x;
        r_xx <= i_quat_x * i_quat_x;
        r_yy <= i_quat_y * i_quat_y;
        r_zz <= i_quat_z * i_quat_z;
    end

    // ---------------- stage 2: product term sums ----------------
    logic signed [SUMW-1:0] r_sr, r_cr, r_sy, r_cy, r_sp;
    logic signed [SUMW-1:0] n_sp;

    assign n_sp = (SUMW'(r_wy) - SUMW'(r_zx)) <<< 1;

    always_ff @(posedge i_clk) begin
        r_sr <= (SUMW'(r_wx) + SUMW'(r_yz)) <<< 1;
        r_cr <= ONE_Q28 - ((SUMW'(r_xx) + SUMW'(r_yy)) <<< 1);
        r_sy <= (SUMW'(r_wz) + SUMW'(r_xy)) <<< 1;
        r_cy <= ONE_Q28 - ((SUMW'(r_yy) + SUMW'(r_zz)) <<< 1);
        r_sp <= n_sp;
    end

    // ---------------- delay line beside the square root ----------------
    typedef struct packed {
        logic signed [SUMW-1:0] sr;
        logic signed [SUMW-1:0] cr;
        logic signed [SUMW-1:0] sy;
        logic signed [SUMW-1:0] cy;
        logic signed [SUMW-1:0] sp;
        logic                   cpos;
        logic                   cneg;
    } t_dly;

    t_dly r_dl [0:DLY-1];

    always_ff @(posedge i_clk) begin
        r_dl[0].sr   <= r_sr;
        r_dl[0].cr   <= r_cr;
        r_dl[0].sy   <= r_sy;
        r_dl[0].cy   <= r_cy;
        r_dl[0].sp   <= r_sp;
        r_dl[0].cpos <= r_sp >= ONE_Q28;
        r_dl[0].cneg <= r_sp <= -ONE_Q28;
        for (int k = 1; k < DLY; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    // ---------------- stage 3/4: square and radicand ----------------
    logic [SUMW-1:0]     sp_abs;
    logic [55:0]         r_sq;
    logic [SQW-1:0]      r_rad;

    assign sp_abs = (r_sp < 0) ? SUMW'(-r_sp) : SUMW'(r_sp);

    always_ff @(posedge i_clk) begin
        r_sq  <= sp_abs[27:0] * sp_abs[27:0];
        r_rad <= (SQW'(1) << 56) - SQW'(r_sq);
    end

    // ---------------- restoring square root, one bit per stage ----------------
    logic [SQW-1:0] r_rv [0:SQ_STEPS];
    logic [SQW-1:0] r_rr [0:SQ_STEPS];

    assign r_rv[0] = r_rad;
    assign r_rr[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SQW-1:0] trial;
        assign trial = r_rr[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_rv[k] >= trial) begin
                r_rv[k+1] <= r_rv[k] - trial;
                r_rr[k+1] <= (r_rr[k] >> 1) + BIT;
            end else begin
                r_rv[k+1] <= r_rv[k];
                r_rr[k+1] <= r_rr[k] >> 1;
            end
        end
    end

    // ---------------- CORDIC units ----------------
    logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk),
        .i_y   (r_dl[DLY-1].sr),
        .i_x   (r_dl[DLY-1].cr),
        .o_z   (z_roll)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk),
        .i_y   (r_dl[DLY-1].sp),
        .i_x   ($signed(SUMW'(r_rr[SQ_STEPS]))),
        .o_z   (z_pitch)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk (i_clk),
        .i_y   (r_dl[DLY-1].sy),
        .i_x   (r_dl[DLY-1].cy),
        .o_z   (z_yaw)
    );

    // clamp flags ride beside the CORDIC stages
    logic [1:0] r_cl [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_cl[0] <= {r_dl[DLY-1].cpos, r_dl[DLY-1].cneg};
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            r_cl[k] <= r_cl[k-1];
        end
    end

    logic signed [ZW-1:0] z_pitch_f;

    always_comb begin
        z_pitch_f = z_pitch;
        if (r_cl[CORDIC_STEPS][1]) begin
            z_pitch_f = HALF_PI_Q30;
        end else if (r_cl[CORDIC_STEPS][0]) begin
            z_pitch_f = -HALF_PI_Q30;
        end
    end

    // ---------------- output stage A: radian round, degree partials ----------------
    localparam int HL = 17;
    localparam int HH = ZW - HL;
    localparam int PLW = HL + DEGK_W;
    localparam int PHW = HH + DEGK_W + 1;
    localparam int SW = 66;

    logic signed [ZW-1:0]  zin  [0:2];
    logic signed [AW-1:0]  r_rad_a [0:2];
    logic [PLW-1:0]        r_pl [0:2];
    logic signed [PHW-1:0] r_ph [0:2];
    logic signed [AW-1:0]  r_ang [0:2];
    logic                  r_clo;

    assign zin[0] = z_roll;
    assign zin[1] = z_pitch_f;
    assign zin[2] = z_yaw;

    for (genvar c = 0; c < 3; c++) begin : g_conv
        logic signed [ZW+4:0] rnd;
        logic signed [SW-1:0] acc;
        assign rnd = (ZW+5)'(zin[c]) + (ZW+5)'(8192);
        assign acc = (SW'(r_ph[c]) <<< HL) + SW'(r_pl[c]) + (SW'(1) << 37);
        always_ff @(posedge i_clk) begin
            r_rad_a[c] <= rnd[AW+13:14];
            r_pl[c]    <= zin[c][HL-1:0] * DEG_K_Q24;
            r_ph[c]    <= $signed(zin[c][ZW-1:HL]) * $signed({1'b0, DEG_K_Q24});
        end
        // ---------------- output stage B: select unit ----------------
        always_ff @(posedge i_clk) begin
            r_ang[c] <= r_deg ? acc[AW+37:38] : r_rad_a[c];
        end
    end

    assign o_roll_angle  = r_ang[0];
    assign o_pitch_angle = r_ang[1];
    assign o_yaw_angle   = r_ang[2];

    always_ff @(posedge i_clk) begin
        r_clo <= r_cl[CORDIC_STEPS][1] || r_cl[CORDIC_STEPS][0];
        o_pitch_clamped <= r_clo && r_vld[LAT-2];
    end

    assign o_valid = r_vld[LAT-1];

    // ---------------- assertions ----------------
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##(LAT) o_valid)
        else $error("result beat missing after fixed latency");

    a_clamp_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pitch_clamped |-> o_valid)
        else $error("pitch clamp flag without a result beat");

    a_clamp_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pitch_clamped |-> o_pitch_angle != '0)
        else $error("clamped pitch reads zero");

endmodule

[hw/rtl/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: one quadrant fold stage, then one register
// stage per iteration. Gives atan2(y, x) with 30 fraction bits.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STEPS = qte_pkg::STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic signed [qte_pkg::SUMW-1:0]   i_y,
    input  logic signed [qte_pkg::SUMW-1:0]   i_x,
    output logic signed [qte_pkg::ZW-1:0]     o_z
);
    import qte_pkg::*;

    logic signed [XW-1:0] r_x    [0:STEPS];
    logic signed [XW-1:0] r_y    [0:STEPS];
    logic signed [ZW-1:0] r_z    [0:STEPS];
    logic                 r_zero [0:STEPS];

    logic signed [XW-1:0] n_x0, n_y0, ex, ey;
    logic signed [ZW-1:0] n_z0;

    assign ex = XW'(i_x);
    assign ey = XW'(i_y);

    // fold the left half plane onto the right one
    always_comb begin
        n_x0 = ex;
        n_y0 = ey;
        n_z0 = '0;
        if (ex < 0) begin
            if (ey >= 0) begin
                n_x0 = ey;
                n_y0 = -ex;
                n_z0 = HALF_PI_Q30;
            end else begin
                n_x0 = -ey;
                n_y0 = ex;
                n_z0 = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
        r_zero[0] <= (ex == '0) && (ey == '0);
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [XW-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + atan_q30(i);
            end else begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - atan_q30(i);
            end
        end
    end

    assign o_z = r_zero[STEPS] ? '0 : r_z[STEPS];

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion to Euler angle converter. A table
// of directed quaternions, then random beats in bursts, run in radian and
// degree mode. A bit-true CORDIC predictor computes each expected beat.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qte_pkg::*;

    localparam int N_STEPS    = 16;
    localparam int PIPE_LAT   = N_STEPS + 36;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_RANDOM   = 1500;
    localparam longint ONE28  = 64'sd268435456;
    localparam longint HPI30  = 64'sd1686629713;
    localparam longint DEGK24 = 64'sd961263669;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic                 clamped;
    } t_euler;

    typedef struct {
        shortint w, x, y, z;
        bit      typed;       // pitch and flag typed in below
        int      pitch;
        bit      clamped;
    } t_quat_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_data = 1'b0;
    logic signed [QW-1:0]  i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic                  o_valid;
    logic signed [AW-1:0]  o_roll_angle, o_pitch_angle, o_yaw_angle;
    logic                  o_pitch_clamped;

    quaternion_to_euler u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_quat_w        (i_quat_w),
        .i_quat_x        (i_quat_x),
        .i_quat_y        (i_quat_y),
        .i_quat_z        (i_quat_z),
        .o_valid         (o_valid),
        .o_roll_angle    (o_roll_angle),
        .o_pitch_angle   (o_pitch_angle),
        .o_yaw_angle     (o_yaw_angle),
        .o_pitch_clamped (o_pitch_clamped)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the degrees select, expected angles in flight, and tallies.
    bit     deg_sel = 1'b0;
    t_euler angles_q[$];
    int     n_errors = 0;
    int     n_beats_in = 0;
    int     n_beats_out = 0;
    int     n_clamped = 0;
    int     idle_cycles = 0;
    bit     accepted_now = 1'b0;

    localparam longint ATAN_Q30[16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    // Vectoring CORDIC: angle of (xv, yv) with 30 fraction bits.
    function automatic longint vector_angle(longint yv, longint xv);
        longint acc, t, dx, dy;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        // fold the left half plane by a quarter turn
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv; yv = -t; acc = HPI30;
            end else begin
                xv = -yv; yv = t; acc = -HPI30;
            end
        end
        for (int i = 0; i < N_STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv += dx; yv -= dy; acc += ATAN_Q30[i];
            end else begin
                xv -= dx; yv += dy; acc -= ATAN_Q30[i];
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [AW-1:0] to_units(longint ang);
        longint v;
        if (deg_sel) v = (ang * DEGK24 + (64'sd1 <<< 37)) >>> 38;
        else         v = (ang + 8192) >>> 14;
        return v[AW-1:0];
    endfunction

    function automatic t_euler euler_of(shortint qw, shortint qx, shortint qy, shortint qz);
        longint w, x, y, z, sr, cr, sy, cy, sp, pang;
        t_euler r;
        w = qw; x = qx; y = qy; z = qz;
        sr = 2 * (w * x + y * z);
        cr = ONE28 - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = ONE28 - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        r.clamped = 1'b0;
        if (sp >= ONE28) begin
            pang = HPI30; r.clamped = 1'b1;
        end else if (sp <= -ONE28) begin
            pang = -HPI30; r.clamped = 1'b1;
        end else begin
            pang = vector_angle(sp,
                longint'(floor_sqrt((64'd1 << 56) - longint'(sp * sp))));
        end
        r.roll  = to_units(vector_angle(sr, cr));
        r.pitch = to_units(pang);
        r.yaw   = to_units(vector_angle(sy, cy));
        return r;
    endfunction

    // Directed rows: extremes, gimbal lock both ways, axis turns, corners.
    // Pitch at a quarter turn in radians is 102944 (clamped), typed below.
    // A level pitch lands one step above zero: sixteen CORDIC steps leave a
    // small positive residue.
    t_quat_row directed[] = '{
        '{16384, 0, 0, 0, 1'b1, 1, 1'b0},
        '{0, 16384, 0, 0, 1'b0, 0, 1'b0},
        '{0, 0, 16384, 0, 1'b0, 0, 1'b0},
        '{0, 0, 0, 16384, 1'b0, 0, 1'b0},
        '{-16384, 0, 0, 0, 1'b1, 1, 1'b0},
        '{0, 0, 0, 0, 1'b1, 1, 1'b0},
        '{16384, 0, 16384, 0, 1'b1, 102944, 1'b1},
        '{16384, 0, -16384, 0, 1'b1, -102944, 1'b1},
        '{11585, 0, 11586, 0, 1'b0, 0, 1'b0},
        '{11585, 0, 11585, 0, 1'b0, 0, 1'b0},
        '{0, 11585, 0, -11586, 1'b0, 0, 1'b0},
        '{0, 11586, 0, 11585, 1'b0, 0, 1'b0},
        '{11585, 11585, 0, 0, 1'b0, 0, 1'b0},
        '{11585, -11585, 0, 0, 1'b0, 0, 1'b0},
        '{11585, 0, 0, 11585, 1'b0, 0, 1'b0},
        '{11585, 0, 0, -11585, 1'b0, 0, 1'b0},
        '{8192, 8192, 8192, 8192, 1'b0, 0, 1'b0},
        '{-8192, 8192, -8192, 8192, 1'b0, 0, 1'b0},
        '{32767, 32767, 32767, 32767, 1'b0, 0, 1'b0},
        '{-32768, -32768, -32768, -32768, 1'b0, 0, 1'b0},
        '{32767, -32768, 32767, -32768, 1'b0, 0, 1'b0},
        '{16384, 16384, 16384, 16384, 1'b0, 0, 1'b0},
        '{0, -16384, 0, 0, 1'b0, 0, 1'b0},
        '{1, -1, 1, -1, 1'b0, 0, 1'b0}
    };
    bit     typed_q[$];
    int     typed_pitch_q[$];
    bit     typed_clamp_q[$];

    // Drive one beat and hold it until a low busy lets it in at an edge.
    task automatic send_quat(shortint w, shortint x, shortint y, shortint z,
                             bit typed, int tpitch, bit tclamp);
        bit was_busy;
        start    <= 1'b1;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        forever begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy) break;
        end
        angles_q.push_back(euler_of(w, x, y, z));
        typed_q.push_back(typed);
        typed_pitch_q.push_back(tpitch);
        typed_clamp_q.push_back(tclamp);
        n_beats_in++;
        accepted_now = 1'b1;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drain the pipe, let it settle, then write the degrees select.
    task automatic write_units(bit deg);
        idle_gap(1);
        while (angles_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= deg;
        deg_sel = deg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic shortint rand_comp(int mode);
        case (mode)
            0: return shortint'($urandom_range(32768) - 16384);
            1: return shortint'($urandom());
            default: return shortint'($urandom_range(64) - 32);
        endcase
    endfunction

    task automatic random_quat();
        shortint w, x, y, z;
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) begin
            w = rand_comp(0); x = rand_comp(0); y = rand_comp(0); z = rand_comp(0);
        end else if (sel < 70) begin
            w = rand_comp(1); x = rand_comp(1); y = rand_comp(1); z = rand_comp(1);
        end else if (sel < 90) begin
            // near gimbal lock: w*y - z*x close to one half either side
            w = shortint'(11585 + rand_comp(2));
            y = shortint'(($urandom_range(1) ? 11585 : -11585) + rand_comp(2));
            x = rand_comp(2);
            z = rand_comp(2);
        end else begin
            // single axis turns, small other terms
            w = rand_comp(0); x = rand_comp(2); y = rand_comp(2); z = rand_comp(2);
            case ($urandom_range(2))
                0: x = rand_comp(0);
                1: y = rand_comp(0);
                default: z = rand_comp(0);
            endcase
        end
        send_quat(w, x, y, z, 1'b0, 0, 1'b0);
    endtask

    // Check each result beat against the oldest expectation.
    always @(negedge i_clk) begin
        t_euler e;
        bit t;
        int tp;
        bit tc;
        if (i_rst_n && o_valid) begin
            n_beats_out++;
            if (o_pitch_clamped) n_clamped++;
            if (angles_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                e  = angles_q.pop_front();
                t  = typed_q.pop_front();
                tp = typed_pitch_q.pop_front();
                tc = typed_clamp_q.pop_front();
                if (t && (e.pitch != tp || e.clamped != tc)) begin
                    $error("table pitch: expected %0d/%0d, predictor %0d/%0d",
                           tp, tc, e.pitch, e.clamped);
                    n_errors++;
                end
                if (o_roll_angle !== e.roll) begin
                    $error("roll_angle: expected %0d, got %0d", e.roll, o_roll_angle);
                    n_errors++;
                end
                if (o_pitch_angle !== e.pitch) begin
                    $error("pitch_angle: expected %0d, got %0d", e.pitch, o_pitch_angle);
                    n_errors++;
                end
                if (o_yaw_angle !== e.yaw) begin
                    $error("yaw_angle: expected %0d, got %0d", e.yaw, o_yaw_angle);
                    n_errors++;
                end
                if (o_pitch_clamped !== e.clamped) begin
                    $error("pitch_clamped: expected %0d, got %0d",
                           e.clamped, o_pitch_clamped);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles where no beat moves either way.
    always @(posedge i_clk) begin
        if (accepted_now || o_valid) idle_cycles <= 0;
        else                         idle_cycles <= idle_cycles + 1;
        accepted_now = 1'b0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int burst;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            write_units(ph[0]);
            // the table runs once per unit setting; typed values hold in radians
            if (ph < 2) begin
                foreach (directed[k]) begin
                    send_quat(directed[k].w, directed[k].x, directed[k].y,
                              directed[k].z, directed[k].typed && !deg_sel,
                              directed[k].pitch, directed[k].clamped);
                    if ($urandom_range(3) == 0) idle_gap($urandom_range(1, 3));
                end
            end
            burst = 0;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                random_quat();
                if (burst == 0) begin
                    idle_gap($urandom_range(0, 12));
                    burst = $urandom_range(1, 40);
                end else begin
                    burst--;
                end
            end
        end
        idle_gap(1);
        while (angles_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        $display("Covered %0d beats in, %0d out, %0d clamped pitch, both unit modes.",
                 n_beats_in, n_beats_out, n_clamped);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
